[hdl/kpl_pkg.sv]
package kpl_pkg;

  localparam int EVT_TYPE_W = 5;
  localparam int EVT_CODE_W = 10;
  localparam int EVT_VAL_W  = 10;
  localparam int KEY_W      = 4;
  localparam int DIGITS_W   = 3;
  localparam int VERDICT_W  = 2;
  localparam int FAIL_W     = 4;
  localparam int X_W        = 10;
  localparam int Y_W        = 9;
  localparam int PASS_W     = 24;
  localparam int LIMIT_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam int NUM_KEYS   = 12;

  localparam logic [EVT_TYPE_W-1:0] TYPE_ABS    = 5'd3;
  localparam logic [EVT_CODE_W-1:0] CODE_X      = 10'd0;
  localparam logic [EVT_CODE_W-1:0] CODE_Y      = 10'd1;
  localparam logic [EVT_CODE_W-1:0] CODE_TOUCH  = 10'd330;
  localparam logic [EVT_VAL_W-1:0]  VAL_RELEASE = 10'd0;

  localparam logic [KEY_W-1:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [KEY_W-1:0] KEY_BACK       = 4'd10;
  localparam logic [KEY_W-1:0] KEY_OK         = 4'd11;
  localparam logic [KEY_W-1:0] KEY_NONE       = 4'd12;

  localparam logic [VERDICT_W-1:0] VERDICT_ENTERING = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_WRONG    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PASSCODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 1'b1;

  localparam logic [PASS_W-1:0]  PASS_RESET  = 24'h147159;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;
  localparam logic [FAIL_W-1:0]  FAIL_MAX    = 4'd15;

  localparam logic [14:0] X_SCALE_MUL = 15'd25;
  localparam logic [23:0] Y_SCALE_MUL = 24'd13108;
  localparam logic [Y_W-1:0] Y_SAT    = 9'd511;

  typedef enum logic [1:0] {
    PH_ENTERING = 2'd0,
    PH_UNLOCKED = 2'd1,
    PH_LOCKED   = 2'd3
  } phase_t;

  typedef logic [X_W-1:0] bound_t;

  // x_lo, x_hi, y_lo, y_hi, exclusive, in priority order
  localparam bound_t KEY_AREA [NUM_KEYS][4] = '{
    '{10'd322, 10'd478, 10'd404, 10'd480}, '{10'd165, 10'd322, 10'd178, 10'd253},
    '{10'd322, 10'd478, 10'd178, 10'd253}, '{10'd478, 10'd636, 10'd178, 10'd253},
    '{10'd165, 10'd322, 10'd253, 10'd328}, '{10'd266, 10'd535, 10'd253, 10'd328},
    '{10'd536, 10'd800, 10'd253, 10'd328}, '{10'd165, 10'd322, 10'd328, 10'd404},
    '{10'd266, 10'd535, 10'd328, 10'd404}, '{10'd478, 10'd636, 10'd328, 10'd404},
    '{10'd165, 10'd322, 10'd404, 10'd480}, '{10'd478, 10'd636, 10'd404, 10'd480}
  };

  typedef struct packed {
    logic [KEY_W-1:0]     key_pressed;
    logic [DIGITS_W-1:0]  digits_entered;
    logic [VERDICT_W-1:0] verdict;
    logic [FAIL_W-1:0]    failure_count;
  } result_t;

endpackage

[hdl/kpl_in_if.sv]
interface kpl_in_if import kpl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [EVT_TYPE_W-1:0] event_type;
  logic [EVT_CODE_W-1:0] event_code;
  logic [EVT_VAL_W-1:0]  event_value;

  modport source (output valid, event_type, event_code, event_value, input ready);
  modport sink   (input valid, event_type, event_code, event_value, output ready);
endinterface

[hdl/kpl_out_if.sv]
interface kpl_out_if import kpl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KEY_W-1:0]     key_pressed;
  logic [DIGITS_W-1:0]  digits_entered;
  logic [VERDICT_W-1:0] verdict;
  logic [FAIL_W-1:0]    failure_count;

  modport source (output valid, key_pressed, digits_entered, verdict, failure_count,
                  input ready);
  modport sink   (input valid, key_pressed, digits_entered, verdict, failure_count,
                  output ready);
endinterface

[hdl/kpl_key_decode.sv]
module kpl_key_decode import kpl_pkg::*; (
  input  logic [X_W-1:0]   touch_x,
  input  logic [Y_W-1:0]   touch_y,
  output logic [KEY_W-1:0] key
);

  logic [X_W-1:0]      y_ext;
  logic [NUM_KEYS-1:0] hit;

  assign y_ext = {1'b0, touch_y};

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      hit[k] = (touch_x > KEY_AREA[k][0]) && (touch_x < KEY_AREA[k][1]) &&
               (y_ext > KEY_AREA[k][2]) && (y_ext < KEY_AREA[k][3]);
    end
  end

  // lowest code wins
  always_comb begin
    key = KEY_NONE;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        key = KEY_W'(k);
      end
    end
  end

endmodule

[hdl/touch_keypad_code_lock.sv]
// Result: a touch-release word taken into the input register passes to the result
//   register, and the result is held there until it is taken.
// Throughput: one event word per cycle, set by the single input-register to
//   result-register pass; a stalled result holds the input register, then the input.
// Reset: synchronous, active low; clears point, digit buffer, count, failures and
//   phase, and loads passcode 0x147159 and attempt limit 3.
module touch_keypad_code_lock import kpl_pkg::*; #(
  parameter int CODE_LENGTH = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  kpl_in_if.sink                in_evt,
  kpl_out_if.source             out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(CODE_LENGTH + 1);
  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_LENGTH);

  logic                  in_vld_r;
  logic [EVT_TYPE_W-1:0] type_r;
  logic [EVT_CODE_W-1:0] code_r;
  logic [EVT_VAL_W-1:0]  val_r;

  logic [PASS_W-1:0]  pass_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [X_W-1:0]     x_r, x_nxt;
  logic [Y_W-1:0]     y_r, y_nxt;
  logic [KEY_W-1:0]   buf_r   [CODE_LENGTH];
  logic [KEY_W-1:0]   buf_nxt [CODE_LENGTH];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FAIL_W-1:0]  fail_r, fail_nxt;
  phase_t             phase_r, phase_nxt;

  logic    out_vld_r, out_vld_nxt;
  result_t res_r, res_nxt;

  logic                  adv, fire, release_evt;
  logic [14:0]           prod_x;
  logic [23:0]           prod_y;
  logic [X_W-1:0]        y_full;
  logic [KEY_W-1:0]      key;
  logic                  match;
  logic                  wrong;
  logic [31:0]           pass_ext;
  logic [VERDICT_W-1:0]  verdict;

  assign adv          = !out_vld_r || out_res.ready;
  assign in_evt.ready = !in_vld_r || adv;
  assign fire         = in_vld_r && adv;
  assign release_evt  = (code_r == CODE_TOUCH) && (val_r == VAL_RELEASE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_evt.ready) begin
      in_vld_r <= in_evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_evt.valid && in_evt.ready) begin
      type_r <= in_evt.event_type;
      code_r <= in_evt.event_code;
      val_r  <= in_evt.event_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r  <= PASS_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PASSCODE: pass_r  <= cfg_wdata[PASS_W-1:0];
        CFG_LIMIT:    limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // x = v*25/32, y = v*4/5 through reciprocal 13108/2^14
  assign prod_x = {5'b0, val_r} * X_SCALE_MUL;
  assign prod_y = {14'b0, val_r} * Y_SCALE_MUL;
  assign y_full = prod_y[23:14];

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (type_r == TYPE_ABS && code_r == CODE_X) begin
      x_nxt = prod_x[14:5];
    end
    if (type_r == TYPE_ABS && code_r == CODE_Y) begin
      y_nxt = (y_full > {1'b0, Y_SAT}) ? Y_SAT : y_full[Y_W-1:0];
    end
  end

  kpl_key_decode u_key_decode (
    .touch_x (x_r),
    .touch_y (y_r),
    .key     (key)
  );

  assign pass_ext = {8'b0, pass_r};

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (release_evt && phase_r == PH_ENTERING) begin
      if (key <= KEY_LAST_DIGIT) begin
        if (cnt_r < CNT_FULL) begin
          buf_nxt[cnt_r[IDX_W-1:0]] = key;
          cnt_nxt = cnt_r + 1'b1;
        end
      end else if (key == KEY_BACK) begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end else if (key == KEY_OK) begin
        cnt_nxt = CNT_FULL;
      end
    end
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (buf_nxt[i] != pass_ext[4*(CODE_LENGTH-1-i) +: 4]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    fail_nxt  = fail_r;
    verdict   = VERDICT_ENTERING;
    wrong     = 1'b0;
    if (release_evt && phase_r == PH_ENTERING && cnt_nxt >= CNT_FULL) begin
      if (match) begin
        phase_nxt = PH_UNLOCKED;
      end else begin
        if (fail_r < FAIL_MAX) begin
          fail_nxt = fail_r + 1'b1;
        end
        verdict = VERDICT_WRONG;
        wrong   = 1'b1;
        if (fail_nxt >= limit_r) begin
          phase_nxt = PH_LOCKED;
        end
      end
    end
    if (phase_nxt != PH_ENTERING) begin
      verdict = phase_nxt;
    end
  end

  logic [CNT_W-1:0] cnt_final;
  assign cnt_final = wrong ? '0 : cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r     <= '0;
      y_r     <= '0;
      cnt_r   <= '0;
      fail_r  <= '0;
      phase_r <= PH_ENTERING;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        buf_r[i] <= '0;
      end
    end else if (fire) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      cnt_r   <= cnt_final;
      fail_r  <= fail_nxt;
      phase_r <= phase_nxt;
      buf_r   <= buf_nxt;
    end
  end

  always_comb begin
    res_nxt.key_pressed    = key;
    res_nxt.digits_entered = DIGITS_W'(cnt_final);
    res_nxt.verdict        = verdict;
    res_nxt.failure_count  = fail_nxt;
    out_vld_nxt            = out_vld_r;
    if (adv) begin
      out_vld_nxt = in_vld_r && release_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid          = out_vld_r;
  assign out_res.key_pressed    = res_r.key_pressed;
  assign out_res.digits_entered = res_r.digits_entered;
  assign out_res.verdict        = res_r.verdict;
  assign out_res.failure_count  = res_r.failure_count;

`ifndef SYNTHESIS
  a_final_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_ENTERING) |=> (phase_r == $past(phase_r) && $stable(fail_r)))
    else $error("phase or failures changed after unlock or lockout");

  a_fail_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (fail_r == $past(fail_r) || fail_r == $past(fail_r) + 1'b1))
    else $error("failure count jumped");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("digit count beyond code length");

  a_wrong_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.verdict == VERDICT_WRONG) |-> (out_res.digits_entered == '0))
    else $error("wrong code left digits in buffer");
`endif

endmodule
